[hw/rtl/clook_pkg.sv]
package clook_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TrackBitsDef  = 16;

  localparam int unsigned IdW     = 8;
  localparam int unsigned TrackW  = 16;
  localparam int unsigned OccW    = 5;
  localparam int unsigned StatusW = 2;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_GET = 1'b1;

  localparam logic [StatusW-1:0] ST_ADDED = 2'd0;
  localparam logic [StatusW-1:0] ST_GIVEN = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd3;

  localparam logic SWEEP_CUR  = 1'b0;
  localparam logic SWEEP_NEXT = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [IdW-1:0]    req_id;
    logic [TrackW-1:0] req_track;
    logic [TrackW-1:0] head_track;
  } in_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     out_id;
    logic [TrackW-1:0]  out_track;
    logic [OccW-1:0]    occupancy;
  } out_req_t;

  typedef struct packed {
    logic ins;
    logic pop;
    logic new_swp;
  } cell_ctl_t;

endpackage

[hw/rtl/clook_cell.sv]
module clook_cell
  import clook_pkg::*;
#(
  parameter int unsigned TRACK_BITS = TrackBitsDef
) (
  input  logic                  clk_i,
  input  cell_ctl_t             ctl_i,
  input  logic [TRACK_BITS-1:0] new_trk_i,
  input  logic [IdW-1:0]        new_id_i,
  input  logic                  valid_i,
  input  logic                  left_valid_i,
  input  logic                  left_after_i,
  input  logic [TRACK_BITS-1:0] left_trk_i,
  input  logic [IdW-1:0]        left_id_i,
  input  logic                  left_swp_i,
  input  logic [TRACK_BITS-1:0] right_trk_i,
  input  logic [IdW-1:0]        right_id_i,
  input  logic                  right_swp_i,
  output logic [TRACK_BITS-1:0] trk_o,
  output logic [IdW-1:0]        id_o,
  output logic                  swp_o,
  output logic                  after_o
);

  logic [TRACK_BITS-1:0] trk_q, trk_d;
  logic [IdW-1:0]        id_q, id_d;
  logic                  swp_q, swp_d;

  // entry sorts strictly after the incoming key (sweep, track)
  assign after_o = valid_i &&
                   ((swp_q != ctl_i.new_swp) ? (swp_q == SWEEP_NEXT)
                                             : (trk_q > new_trk_i));

  always_comb begin
    trk_d = trk_q;
    id_d  = id_q;
    swp_d = swp_q;
    if (ctl_i.ins) begin
      if (left_after_i) begin
        trk_d = left_trk_i;
        id_d  = left_id_i;
        swp_d = left_swp_i;
      end else if ((after_o || !valid_i) && left_valid_i) begin
        trk_d = new_trk_i;
        id_d  = new_id_i;
        swp_d = ctl_i.new_swp;
      end
    end else if (ctl_i.pop) begin
      trk_d = right_trk_i;
      id_d  = right_id_i;
      swp_d = right_swp_i;
    end
  end

  always_ff @(posedge clk_i) begin
    trk_q <= trk_d;
    id_q  <= id_d;
    swp_q <= swp_d;
  end

  assign trk_o = trk_q;
  assign id_o  = id_q;
  assign swp_o = swp_q;

endmodule

[hw/rtl/clook_request_queue_core.sv]
// C-LOOK disk request queue.
// Input channel: in_valid_i / in_stall_o carry an in_req_t request, either an
// add (id, track, head track at the time of the add) or a get.
// Output channel: out_valid_o / out_stall_i carry one out_req_t per request:
// status, id and track of a given request, and occupancy after the request.
// Entries sit in a chain of cells sorted by (sweep, track); an add shifts the
// entries after its slot one cell back, a get shifts the chain forward.
// An accepted request is held in the request register; its result is then
// registered in the output register. The input stalls while the request
// register is busy, so the cell chain updates before the next is accepted.
// A result waiting in the output register does not block acceptance; if the
// receiver stalls, the pending request waits in its register and the input
// is stalled until the output register frees.
// Reset empties the queue; the first request may be accepted right after.
// A get on an empty queue and an add to a full queue report their status
// and leave the queue unchanged.
module clook_request_queue_core
  import clook_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned TRACK_BITS  = TrackBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic            req_valid_q, req_valid_d;
  in_req_t         req_q;
  logic            out_valid_q, out_valid_d;
  out_req_t        out_q, out_d;
  logic [CntW-1:0] count_q, count_d;

  logic [TRACK_BITS-1:0] trk_w [QUEUE_DEPTH];
  logic [IdW-1:0]        id_w  [QUEUE_DEPTH];
  logic                  swp_w [QUEUE_DEPTH];
  logic                  after_w [QUEUE_DEPTH];
  logic                  valid_w [QUEUE_DEPTH];

  logic [TRACK_BITS-1:0] new_trk, new_head;
  logic                  do_proc, is_add, empty, full;
  cell_ctl_t             ctl;

  assign new_trk  = TRACK_BITS'(req_q.req_track);
  assign new_head = TRACK_BITS'(req_q.head_track);
  assign do_proc  = req_valid_q && (!out_valid_q || !out_stall_i);
  assign is_add   = (req_q.cmd == CMD_ADD);
  assign empty    = (count_q == '0);
  assign full     = (count_q == CntW'(QUEUE_DEPTH));

  assign ctl.ins     = do_proc && is_add && !full;
  assign ctl.pop     = do_proc && !is_add && !empty;
  assign ctl.new_swp = (new_trk >= new_head) ? SWEEP_CUR : SWEEP_NEXT;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                  l_valid, l_after, l_swp, r_swp;
    logic [TRACK_BITS-1:0] l_trk, r_trk;
    logic [IdW-1:0]        l_id, r_id;

    assign valid_w[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_first
      assign l_valid = 1'b1;
      assign l_after = 1'b0;
      assign l_trk   = '0;
      assign l_id    = '0;
      assign l_swp   = 1'b0;
    end else begin : g_mid
      assign l_valid = valid_w[i-1];
      assign l_after = after_w[i-1];
      assign l_trk   = trk_w[i-1];
      assign l_id    = id_w[i-1];
      assign l_swp   = swp_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_trk = '0;
      assign r_id  = '0;
      assign r_swp = 1'b0;
    end else begin : g_body
      assign r_trk = trk_w[i+1];
      assign r_id  = id_w[i+1];
      assign r_swp = swp_w[i+1];
    end

    clook_cell #(
      .TRACK_BITS(TRACK_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .new_trk_i   (new_trk),
      .new_id_i    (req_q.req_id),
      .valid_i     (valid_w[i]),
      .left_valid_i(l_valid),
      .left_after_i(l_after),
      .left_trk_i  (l_trk),
      .left_id_i   (l_id),
      .left_swp_i  (l_swp),
      .right_trk_i (r_trk),
      .right_id_i  (r_id),
      .right_swp_i (r_swp),
      .trk_o       (trk_w[i]),
      .id_o        (id_w[i]),
      .swp_o       (swp_w[i]),
      .after_o     (after_w[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctl.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    out_d.status    = ST_ADDED;
    out_d.out_id    = '0;
    out_d.out_track = '0;
    out_d.occupancy = OccW'(count_d);
    if (is_add) begin
      out_d.status = full ? ST_FULL : ST_ADDED;
    end else if (empty) begin
      out_d.status = ST_EMPTY;
    end else begin
      out_d.status    = ST_GIVEN;
      out_d.out_id    = id_w[0];
      out_d.out_track = TrackW'(trk_w[0]);
    end
  end

  always_comb begin
    req_valid_d = req_valid_q;
    if (do_proc) begin
      req_valid_d = 1'b0;
    end
    if (in_valid_i && !in_stall_o) begin
      req_valid_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (do_proc) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q <= in_req_i;
    end
    if (do_proc) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = req_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

[hw/rtl/clook_checker.sv]
module clook_checker
  import clook_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_req_t out_req_o
);

  // a request holds the input for its processing cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted back to back");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.status != ST_GIVEN |->
      out_req_o.out_id == '0 && out_req_o.out_track == '0)
    else $error("payload on non-given status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.status == ST_EMPTY |-> out_req_o.occupancy == '0)
    else $error("empty get with nonzero occupancy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.status == ST_FULL |->
      out_req_o.occupancy == OccW'(QUEUE_DEPTH))
    else $error("full refusal below capacity");

endmodule

bind clook_request_queue_core clook_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_clook_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_req_o  (out_req_o)
);

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import clook_pkg::*;

  localparam int unsigned QDepth = QueueDepthDef;
  localparam logic [TrackW-1:0] TrackMax = '1;

  typedef struct packed {
    logic              sweep;
    logic [TrackW-1:0] track;
    logic [IdW-1:0]    id;
  } held_req_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     req_valid = 1'b0;
  logic     in_stall;
  in_req_t  req_bus = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  out_req_t res_bus;

  in_req_t     pending_reqs[$];
  held_req_t   held_reqs[$];
  out_req_t    expected_results[$];
  int unsigned req_gap = 0;
  int unsigned res_hold = 0;
  int unsigned reqs_sent = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;

  clook_request_queue_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_valid),
    .in_stall_o (in_stall),
    .in_req_i   (req_bus),
    .out_valid_o(res_valid),
    .out_stall_i(res_stall),
    .out_req_o  (res_bus)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_draw(input int unsigned n);
    return ((n >> 7) % 3 == 0) ? 0 : $urandom_range(0, 15);
  endfunction

  // C-LOOK queue kept as one list sorted by (sweep, track), ties in arrival order
  function automatic out_req_t serve_request(input in_req_t r);
    out_req_t  res;
    held_req_t e;
    int unsigned pos;
    res = '0;
    if (r.cmd == CMD_ADD) begin
      if (held_reqs.size() >= QDepth) begin
        res.status = ST_FULL;
      end else begin
        e.id    = r.req_id;
        e.track = r.req_track;
        e.sweep = (r.req_track >= r.head_track) ? SWEEP_CUR : SWEEP_NEXT;
        pos = held_reqs.size();
        for (int i = 0; i < held_reqs.size(); i++) begin
          if (pos == held_reqs.size()) begin
            if (held_reqs[i].sweep != e.sweep) begin
              if (held_reqs[i].sweep > e.sweep) pos = i;
            end else if (held_reqs[i].track > e.track) begin
              pos = i;
            end
          end
        end
        held_reqs.insert(pos, e);
        res.status = ST_ADDED;
      end
    end else if (held_reqs.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      e = held_reqs.pop_front();
      res.status    = ST_GIVEN;
      res.out_id    = e.id;
      res.out_track = e.track;
    end
    res.occupancy = OccW'(held_reqs.size());
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp);
    $display("tb: mismatch on %s at %0t: got 0x%0h, expected 0x%0h", what, $time, got, exp);
    error_count++;
  endtask

  task automatic push_add(input logic [IdW-1:0] id, input logic [TrackW-1:0] track,
                          input logic [TrackW-1:0] head);
    in_req_t r;
    r.cmd        = CMD_ADD;
    r.req_id     = id;
    r.req_track  = track;
    r.head_track = head;
    pending_reqs.push_back(r);
  endtask

  task automatic push_get();
    in_req_t r;
    r = in_req_t'($urandom());
    r.cmd = CMD_GET;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [TrackW-1:0] pick_track(input logic [TrackW-1:0] near);
    case ($urandom_range(0, 4))
      0:       return TrackW'($urandom_range(0, 7));
      1:       return $urandom_range(0, 1) ? TrackMax : '0;
      2:       return TrackW'(near + $urandom_range(0, 4) - 2);
      default: return TrackW'($urandom());
    endcase
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drv_b
    logic        vld_n;
    in_req_t     req_n;
    int unsigned gap_n;
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_gap   <= 0;
    end else begin
      vld_n = req_valid;
      req_n = req_bus;
      gap_n = req_gap;
      if (req_valid && !in_stall) begin
        expected_results.push_back(serve_request(req_bus));
        reqs_sent++;
        vld_n = 1'b0;
        gap_n = idle_draw(reqs_sent);
      end
      if (!vld_n) begin
        if (gap_n != 0) begin
          gap_n--;
        end else if (pending_reqs.size() != 0) begin
          req_n = pending_reqs.pop_front();
          vld_n = 1'b1;
        end
      end
      req_valid <= vld_n;
      req_bus   <= req_n;
      req_gap   <= gap_n;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : mon_b
    out_req_t    exp;
    int unsigned hold_n;
    if (!rst_ni) begin
      res_stall <= 1'b0;
      res_hold  <= 0;
    end else begin
      hold_n = (res_hold != 0) ? res_hold - 1 : 0;
      if (res_valid && !res_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("tb: unexpected result at %0t: 0x%0h", $time, res_bus);
          error_count++;
        end else begin
          exp = expected_results.pop_front();
          if (res_bus.status !== exp.status)
            report_mismatch("status", res_bus.status, exp.status);
          if (res_bus.out_id !== exp.out_id)
            report_mismatch("out_id", res_bus.out_id, exp.out_id);
          if (res_bus.out_track !== exp.out_track)
            report_mismatch("out_track", res_bus.out_track, exp.out_track);
          if (res_bus.occupancy !== exp.occupancy)
            report_mismatch("occupancy", res_bus.occupancy, exp.occupancy);
        end
        hold_n = idle_draw(results_seen);
      end
      res_hold  <= hold_n;
      res_stall <= (hold_n != 0);
    end
  end

  initial begin
    int unsigned get_pct;
    logic [TrackW-1:0] head;

    // directed
    push_get();
    push_add(8'hFF, TrackMax, '0);
    push_add(8'h00, '0, TrackMax);
    push_add(8'h11, 16'h8000, 16'h8000);
    push_add(8'h22, 16'h8000, 16'h1234);
    push_add(8'h33, 16'd5, 16'd6);
    push_get();
    push_get();
    // current sweep drained except the top track; a new add at or above head goes first
    push_add(8'h44, 16'd100, 16'd50);
    for (int i = 0; i < 11; i++)
      push_add(IdW'(8'h50 + i), TrackW'(16'h0F0F ^ (i * 16'h1111)), 16'h7777);
    push_add(8'hAA, 16'h5555, 16'hAAAA);
    push_get();
    push_get();

    // random, phases lean toward full or empty
    head = TrackW'($urandom());
    while (pending_reqs.size() < 1125) begin
      case ($urandom_range(0, 3))
        0:       get_pct = 15;
        1:       get_pct = 85;
        2:       get_pct = 35;
        default: get_pct = 55;
      endcase
      for (int i = 0; i < 48; i++) begin
        if ($urandom_range(0, 99) < get_pct) begin
          push_get();
        end else begin
          case ($urandom_range(0, 5))
            0:       head = '0;
            1:       head = TrackMax;
            2:       head = TrackW'($urandom());
            default: ;
          endcase
          push_add(IdW'($urandom_range(0, 255)), pick_track(head), head);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

[clook_request_queue_core.f]
hw/rtl/clook_pkg.sv
hw/rtl/clook_cell.sv
hw/rtl/clook_request_queue_core.sv
hw/rtl/clook_checker.sv
tb/tb.sv
